// ===== rtl/slcan_pkg.sv =====
package slcan_pkg;

  localparam int MAX_LINE_DEF = 256;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_T     = 8'h74;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_EIGHT = 8'h38;
  localparam logic [3:0] BAD_LEN    = 4'd15;
  localparam logic [3:0] MAX_DLC    = 4'd8;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BAD_HEX  = 2'd3
  } status_t;

  typedef struct packed {
    logic        vld;
    status_t     status;
    logic [11:0] can_id;
    logic [3:0]  data_len;
    logic [63:0] payload;
  } dec_res_t;

  // msb set when the character is not a hex digit
  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== rtl/slcan_ifs.sv =====
interface slcan_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcan_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] can_id;
  logic [3:0]  data_len;
  logic [63:0] payload;

  modport source (output valid, output status, output can_id, output data_len,
                  output payload, input ready);
  modport sink (input valid, input status, input can_id, input data_len,
                input payload, output ready);
endinterface

// ===== rtl/slcan_line_dec.sv =====
module slcan_line_dec import slcan_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output dec_res_t   res
);

  localparam int POS_W = $clog2(MAX_LINE + 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             frame_r, frame_nxt;
  logic [11:0]      id_r, id_nxt;
  logic [3:0]       len_r, len_nxt;
  logic [63:0]      data_r, data_nxt;
  logic             err_r, err_nxt;
  logic [4:0]       hex;
  logic [POS_W-1:0] k;
  logic [5:0]       sh;

  assign hex = hex_dec(rx_byte);
  assign k   = pos_r - POS_W'(5);
  // even digit is the high nibble of its byte
  assign sh  = {k[3:1], ~k[0], 2'b00};

  always_comb begin
    pos_nxt   = pos_r;
    frame_nxt = frame_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    data_nxt  = data_r;
    err_nxt   = err_r;
    res       = '0;
    if (step) begin
      if (pos_r >= POS_W'(MAX_LINE)) begin
        pos_nxt    = '0;
        frame_nxt  = 1'b0;
        id_nxt     = '0;
        len_nxt    = '0;
        data_nxt   = '0;
        err_nxt    = 1'b0;
        res.vld    = 1'b1;
        res.status = ST_OVERFLOW;
      end else if (rx_byte == CHAR_CR) begin
        pos_nxt   = '0;
        frame_nxt = 1'b0;
        id_nxt    = '0;
        len_nxt   = '0;
        data_nxt  = '0;
        err_nxt   = 1'b0;
        if (frame_r && pos_r >= POS_W'(3)) begin
          res.vld = 1'b1;
          if (pos_r < POS_W'(5) || len_r > MAX_DLC) begin
            res.status = ST_BAD_LEN;
          end else if (err_r || pos_r < POS_W'(5) + POS_W'({len_r, 1'b0})) begin
            res.status = ST_BAD_HEX;
          end else begin
            res.status   = ST_OK;
            res.can_id   = id_r;
            res.data_len = len_r;
            res.payload  = data_r;
          end
        end
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        if (pos_r == '0) begin
          frame_nxt = (rx_byte == CHAR_T);
        end else if (frame_r) begin
          if (pos_r <= POS_W'(3)) begin
            if (hex[4]) begin
              err_nxt = 1'b1;
            end else begin
              id_nxt = {id_r[7:0], hex[3:0]};
            end
          end else if (pos_r == POS_W'(4)) begin
            if (rx_byte >= CHAR_ZERO && rx_byte <= CHAR_EIGHT) begin
              len_nxt = 4'(rx_byte - CHAR_ZERO);
            end else begin
              len_nxt = BAD_LEN;
            end
          end else if (len_r <= MAX_DLC && k < POS_W'({len_r, 1'b0})) begin
            if (hex[4]) begin
              err_nxt = 1'b1;
            end else begin
              data_nxt = data_r | (64'(hex[3:0]) << sh);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      frame_r <= 1'b0;
      id_r    <= '0;
      len_r   <= '0;
      data_r  <= '0;
      err_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      frame_r <= frame_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      data_r  <= data_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ===== rtl/slcan_frame_decoder.sv =====
// a result is offered from the result register: each character transfer is
// captured in the input register, then decoded into the result register
// throughput: one character per cycle, held back only while a result waits
// reset: synchronous active low rst_n clears both valid flags and the line
// state, so decoding starts at the beginning of a line
module slcan_frame_decoder import slcan_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  slcan_in_if.sink     in_ch,
  slcan_out_if.source  out_ch
);

  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_byte_r;
  logic        out_vld_r;
  status_t     status_r;
  logic [11:0] can_id_r;
  logic [3:0]  data_len_r;
  logic [63:0] payload_r;
  logic        adv;
  logic        step;
  logic        in_xfer;
  dec_res_t    res;

  assign adv          = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = !in_vld_r || adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign step         = in_vld_r && adv;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_xfer) begin
      in_vld_nxt = 1'b1;
    end else if (step) begin
      in_vld_nxt = 1'b0;
    end
  end

  slcan_line_dec #(
    .MAX_LINE(MAX_LINE)
  ) u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (adv) begin
        out_vld_r <= res.vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (adv) begin
      status_r   <= res.status;
      can_id_r   <= res.can_id;
      data_len_r <= res.data_len;
      payload_r  <= res.payload;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.status   = status_r;
  assign out_ch.can_id   = can_id_r;
  assign out_ch.data_len = data_len_r;
  assign out_ch.payload  = payload_r;

endmodule
